// ----- design/ptt_pkg.sv -----
package ptt_pkg;

  localparam int MaxTimersDefault = 16;
  localparam logic [31:0] TickReset = 32'd781250;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_FIRED     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_DESTROYED = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_FULL      = 3'd5,
    ST_NONE      = 3'd6
  } status_t;

  typedef struct packed {
    req_t        req;
    logic [31:0] addr;
    logic [63:0] start;
    logic [63:0] ival;
    logic [31:0] queue;
    logic [31:0] msg;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CREATE,
    S_SHIFT,
    S_TICK,
    S_EMIT
  } state_t;

endpackage

// ----- design/ptt_front.sv -----
module ptt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [31:0]          in_timer_addr,
  input  logic [63:0]          in_start_count,
  input  logic [63:0]          in_reload_interval,
  input  logic [31:0]          in_queue_addr,
  input  logic [31:0]          in_message,
  output logic                 q_valid,
  input  logic                 q_ready,
  output ptt_pkg::cmd_t        q_cmd
);
  import ptt_pkg::*;

  // two-entry queue between front and back
  cmd_t        buf_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;
  cmd_t        cmd;

  always_comb begin
    cmd.req   = req_t'(in_req_type);
    cmd.addr  = in_timer_addr;
    cmd.start = in_start_count;
    cmd.ival  = in_reload_interval;
    cmd.queue = in_queue_addr;
    cmd.msg   = in_message;
  end

  assign in_ready = (cnt_r != 2'd2);
  // drop unused request type here
  assign push = in_valid && in_ready && (cmd.req != REQ_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = buf_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= cmd;
  end
endmodule

// ----- design/ptt_back.sv -----
module ptt_back #(
  parameter int MaxTimers = ptt_pkg::MaxTimersDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  ptt_pkg::cmd_t        q_cmd,
  input  logic [31:0]          tick_amount,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [31:0]          out_event_queue,
  output logic [31:0]          out_event_message,
  output logic                 out_last
);
  import ptt_pkg::*;

  localparam int IW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
  localparam int CW = $clog2(MaxTimers + 1);

  // entries stay in flops: shifting needs every slot at its own place
  logic [31:0] key_r   [MaxTimers];
  logic [63:0] count_r [MaxTimers];
  logic [63:0] ival_r  [MaxTimers];
  logic [31:0] queue_r [MaxTimers];
  logic [31:0] msg_r   [MaxTimers];

  state_t      state_r, state_nxt;
  cmd_t        cmd_r;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] eq_r, eq_nxt, em_r, em_nxt;
  logic        last_r, last_nxt;
  // fired timer held back until the walk shows whether another one follows
  logic        pend_r, pend_nxt;
  logic [31:0] peq_r, peq_nxt, pem_r, pem_nxt;
  logic [IW-1:0] idx;
  logic        hit;
  logic        out_free;

  logic        wr_en, shift_en, sub_en, add_en, save_pos;

  assign idx = i_r[IW-1:0];
  assign hit = (key_r[idx] == cmd_r.addr);
  assign out_free = !ov_r || out_ready;
  assign q_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_event_queue = eq_r;
  assign out_event_message = em_r;
  assign out_last = last_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    i_nxt = i_r;
    ov_nxt = ov_r && !out_ready;
    st_nxt = st_r;
    eq_nxt = eq_r;
    em_nxt = em_r;
    last_nxt = last_r;
    pend_nxt = pend_r;
    peq_nxt = peq_r;
    pem_nxt = pem_r;
    wr_en = 1'b0;
    shift_en = 1'b0;
    sub_en = 1'b0;
    add_en = 1'b0;
    save_pos = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !ov_r) begin
          i_nxt = '0;
          state_nxt = (q_cmd.req == REQ_TICK) ? S_TICK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (i_r < n_r && hit) begin
          if (cmd_r.req == REQ_CREATE) begin
            state_nxt = S_CREATE;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (i_r < n_r) begin
          i_nxt = i_r + 1'b1;
        end else if (cmd_r.req == REQ_CREATE) begin
          state_nxt = S_CREATE;
        end else begin
          st_nxt = ST_NOTFOUND;
          eq_nxt = '0; em_nxt = '0; last_nxt = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_CREATE: begin
        eq_nxt = '0; em_nxt = '0; last_nxt = 1'b1;
        state_nxt = S_EMIT;
        if (i_r < n_r) begin
          wr_en = 1'b1;
          st_nxt = ST_UPDATED;
        end else if (n_r < CW'(MaxTimers)) begin
          wr_en = 1'b1;
          n_nxt = n_r + 1'b1;
          st_nxt = ST_CREATED;
        end else begin
          st_nxt = ST_FULL;
        end
      end
      S_SHIFT: begin
        // remove entry i by moving later entries down one per cycle
        if (i_r + 1'b1 < n_r) begin
          shift_en = 1'b1;
          i_nxt = i_r + 1'b1;
        end else begin
          n_nxt = n_r - 1'b1;
          if (cmd_r.req == REQ_DESTROY) begin
            st_nxt = ST_DESTROYED;
            eq_nxt = '0; em_nxt = '0; last_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            // resume the walk at the slot that was just refilled
            i_nxt = cmd_r.start[CW-1:0];
            state_nxt = S_TICK;
          end
        end
      end
      S_TICK: begin
        if (i_r < n_r) begin
          if (count_r[idx] >= {32'd0, tick_amount}) begin
            sub_en = 1'b1;
            i_nxt = i_r + 1'b1;
          end else if (!pend_r || out_free) begin
            // another timer fires, so the held one is not the last
            if (pend_r) begin
              ov_nxt = 1'b1;
              st_nxt = ST_FIRED;
              eq_nxt = peq_r;
              em_nxt = pem_r;
              last_nxt = 1'b0;
            end
            pend_nxt = 1'b1;
            peq_nxt = queue_r[idx];
            pem_nxt = msg_r[idx];
            if (ival_r[idx] != '0) begin
              add_en = 1'b1;
              i_nxt = i_r + 1'b1;
            end else begin
              save_pos = 1'b1;
              state_nxt = S_SHIFT;
            end
          end
        end else if (out_free) begin
          ov_nxt = 1'b1;
          last_nxt = 1'b1;
          pend_nxt = 1'b0;
          if (pend_r) begin
            st_nxt = ST_FIRED;
            eq_nxt = peq_r;
            em_nxt = pem_r;
          end else begin
            st_nxt = ST_NONE;
            eq_nxt = '0;
            em_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      ov_r <= ov_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    st_r <= st_nxt;
    eq_r <= eq_nxt;
    em_r <= em_nxt;
    last_r <= last_nxt;
    peq_r <= peq_nxt;
    pem_r <= pem_nxt;
    if (state_r == S_IDLE && q_valid && !ov_r) cmd_r <= q_cmd;
    if (save_pos) cmd_r.start <= {{(64-CW){1'b0}}, i_r};
    if (wr_en) begin
      key_r[idx]   <= cmd_r.addr;
      count_r[idx] <= (cmd_r.start != '0) ? cmd_r.start : cmd_r.ival;
      ival_r[idx]  <= cmd_r.ival;
      queue_r[idx] <= cmd_r.queue;
      msg_r[idx]   <= cmd_r.msg;
    end
    if (shift_en) begin
      key_r[idx]   <= key_r[IW'(i_r + 1'b1)];
      count_r[idx] <= count_r[IW'(i_r + 1'b1)];
      ival_r[idx]  <= ival_r[IW'(i_r + 1'b1)];
      queue_r[idx] <= queue_r[IW'(i_r + 1'b1)];
      msg_r[idx]   <= msg_r[IW'(i_r + 1'b1)];
    end
    if (sub_en) count_r[idx] <= count_r[idx] - {32'd0, tick_amount};
    if (add_en) count_r[idx] <= count_r[idx] + ival_r[idx];
  end
endmodule

// ----- design/periodic_timer_table.sv -----
// Create compares one entry per cycle while it scans the table, then writes the entry;
// destroy scans likewise, then removal shifts later entries down one entry per cycle.
// Tick walks every entry and shifts out each one-shot timer that fires, then gives a
// final result; a fired result waits for the next one.
// One request in the back end at a time, the next starts once its last result is
// taken; a two-deep queue buffers requests. Sync active-low reset empties the table
// and loads tick_amount 781250.
module periodic_timer_table #(
  parameter int MaxTimers = ptt_pkg::MaxTimersDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_timer_addr,
  input  logic [63:0] in_start_count,
  input  logic [63:0] in_reload_interval,
  input  logic [31:0] in_queue_addr,
  input  logic [31:0] in_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_event_queue,
  output logic [31:0] out_event_message,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import ptt_pkg::*;

  logic [31:0] tick_r;
  logic        q_valid, q_ready;
  cmd_t        q_cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tick_r <= TickReset;
    else if (cfg_valid) tick_r <= cfg_data;
  end

  ptt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_timer_addr,
    .in_start_count, .in_reload_interval, .in_queue_addr, .in_message,
    .q_valid, .q_ready, .q_cmd
  );

  ptt_back #(.MaxTimers(MaxTimers)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .tick_amount(tick_r),
    .out_valid, .out_ready, .out_status, .out_event_queue,
    .out_event_message, .out_last
  );
endmodule

// ----- design/ptt_checker.sv -----
module ptt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [31:0] out_event_queue,
  input logic       out_last
);
  import ptt_pkg::*;

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NONE)
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FIRED |-> out_event_queue == '0)
    else $error("queue nonzero");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FIRED |-> out_last)
    else $error("last missing");
endmodule

bind periodic_timer_table ptt_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_status, .out_event_queue, .out_last
);

// ----- verif/periodic_timer_table_tb.sv -----
`timescale 1ns / 1ps

module periodic_timer_table_tb;
  import ptt_pkg::*;

  localparam int NumTimers = MaxTimersDefault;
  localparam int CycleLimit = 1500000;

  typedef struct {
    req_t        req;
    logic [31:0] addr;
    logic [63:0] start;
    logic [63:0] ival;
    logic [31:0] queue;
    logic [31:0] msg;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] queue;
    logic [31:0] msg;
    logic        last;
  } event_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [31:0] in_timer_addr;
  logic [63:0] in_start_count;
  logic [63:0] in_reload_interval;
  logic [31:0] in_queue_addr;
  logic [31:0] in_message;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_event_queue;
  logic [31:0] out_event_message;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  periodic_timer_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_timer_addr(in_timer_addr),
    .in_start_count(in_start_count), .in_reload_interval(in_reload_interval),
    .in_queue_addr(in_queue_addr), .in_message(in_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_event_queue(out_event_queue),
    .out_event_message(out_event_message), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0] tick_amount;
  int          timer_count;
  logic [31:0] key_tbl[NumTimers];
  logic [63:0] count_tbl[NumTimers];
  logic [63:0] ival_tbl[NumTimers];
  logic [31:0] queue_tbl[NumTimers];
  logic [31:0] msg_tbl[NumTimers];

  request_t pending_reqs[$];
  event_t   expected_events[$];
  int       send_idle_pct;
  int       recv_stall_pct;
  int       fail_count;
  longint   cycle_count;
  logic     cfg_pending;
  logic [31:0] cfg_value;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int find_timer(logic [31:0] key);
    for (int i = 0; i < timer_count; i++)
      if (key_tbl[i] == key) return i;
    return timer_count;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < timer_count; i++) begin
      key_tbl[i] = key_tbl[i + 1];
      count_tbl[i] = count_tbl[i + 1];
      ival_tbl[i] = ival_tbl[i + 1];
      queue_tbl[i] = queue_tbl[i + 1];
      msg_tbl[i] = msg_tbl[i + 1];
    end
    timer_count--;
  endfunction

  function automatic void push_event(status_t st, logic [31:0] q, logic [31:0] m,
                                     logic lst);
    event_t ev;
    ev.status = st;
    ev.queue = q;
    ev.msg = m;
    ev.last = lst;
    expected_events.push_back(ev);
  endfunction

  function automatic void predict_timer_events(request_t r);
    int pos;
    int fired;
    int i;
    case (r.req)
      REQ_CREATE: begin
        pos = find_timer(r.addr);
        if (pos < timer_count) begin
          push_event(ST_UPDATED, '0, '0, 1'b1);
        end else if (timer_count < NumTimers) begin
          timer_count++;
          push_event(ST_CREATED, '0, '0, 1'b1);
        end else begin
          push_event(ST_FULL, '0, '0, 1'b1);
          return;
        end
        key_tbl[pos] = r.addr;
        count_tbl[pos] = (r.start != 0) ? r.start : r.ival;
        ival_tbl[pos] = r.ival;
        queue_tbl[pos] = r.queue;
        msg_tbl[pos] = r.msg;
      end
      REQ_DESTROY: begin
        pos = find_timer(r.addr);
        if (pos < timer_count) begin
          drop_timer(pos);
          push_event(ST_DESTROYED, '0, '0, 1'b1);
        end else begin
          push_event(ST_NOTFOUND, '0, '0, 1'b1);
        end
      end
      REQ_TICK: begin
        fired = 0;
        i = 0;
        while (i < timer_count) begin
          if (count_tbl[i] >= {32'd0, tick_amount}) begin
            count_tbl[i] -= {32'd0, tick_amount};
            i++;
          end else begin
            push_event(ST_FIRED, queue_tbl[i], msg_tbl[i], 1'b0);
            fired++;
            if (ival_tbl[i] != 0) begin
              count_tbl[i] += ival_tbl[i];
              i++;
            end else begin
              drop_timer(i);
            end
          end
        end
        if (fired == 0) push_event(ST_NONE, '0, '0, 1'b1);
        else expected_events[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        predict_timer_events(r);
        in_valid <= 1'b1;
        in_req_type <= r.req;
        in_timer_addr <= r.addr;
        in_start_count <= r.start;
        in_reload_interval <= r.ival;
        in_queue_addr <= r.queue;
        in_message <= r.msg;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // config writer
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      cfg_pending <= 1'b0;
    end else if (cfg_pending && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_data <= cfg_value;
    end
  end

  // monitor
  always @(posedge clk) begin
    event_t ev;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result status=%0d queue=%h msg=%h last=%b", $time,
                 out_status, out_event_queue, out_event_message, out_last);
        fail_count++;
      end else begin
        ev = expected_events.pop_front();
        if (out_status !== ev.status || out_event_queue !== ev.queue ||
            out_event_message !== ev.msg || out_last !== ev.last) begin
          $display("%0t: mismatch expected status=%0d queue=%h msg=%h last=%b", $time,
                   ev.status, ev.queue, ev.msg, ev.last);
          $display("%0t:          actual   status=%0d queue=%h msg=%h last=%b", $time,
                   out_status, out_event_queue, out_event_message, out_last);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key();
    // favor existing keys so updates and destroys hit
    if (timer_count > 0 && $urandom_range(99) < 60)
      return key_tbl[$urandom_range(timer_count - 1)];
    return $urandom_range(40);
  endfunction

  function automatic logic [63:0] pick_count();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return {$urandom, $urandom};
      2: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return 64'($urandom_range(400));
    endcase
  endfunction

  task automatic queue_req(req_t kind, logic [31:0] addr, logic [63:0] start,
                           logic [63:0] ival, logic [31:0] q, logic [31:0] m);
    request_t r;
    r.req = kind;
    r.addr = addr;
    r.start = start;
    r.ival = ival;
    r.queue = q;
    r.msg = m;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_random(int num);
    req_t kind;
    for (int n = 0; n < num; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: kind = REQ_CREATE;
        4, 5: kind = REQ_DESTROY;
        9: kind = ($urandom_range(3) == 0) ? REQ_NONE : REQ_TICK;
        default: kind = REQ_TICK;
      endcase
      queue_req(kind, ($urandom_range(9) == 0) ? $urandom : pick_key(), pick_count(),
                pick_count(), $urandom, $urandom);
    end
  endtask

  task automatic drain_and_wait();
    while (pending_reqs.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    // an ignored request is dropped at the input and gives no result
    repeat (60) @(posedge clk);
  endtask

  task automatic set_tick(logic [31:0] value);
    cfg_value = value;
    cfg_pending <= 1'b1;
    @(posedge clk);
    while (cfg_pending) @(posedge clk);
    tick_amount = value;
  endtask

  task automatic run_phase(int idle, int stall, logic [31:0] tick, int num);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    set_tick(tick);
    queue_random(num);
    drain_and_wait();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_timer_addr = '0;
    in_start_count = '0;
    in_reload_interval = '0;
    in_queue_addr = '0;
    in_message = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cfg_pending = 1'b0;
    cfg_value = '0;
    cycle_count = 0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tick_amount = TickReset;
    timer_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset tick amount, empty-table cases, extremes, full table
    queue_req(REQ_TICK, '0, '0, '0, '0, '0);
    queue_req(REQ_DESTROY, 32'hFFFF_FFFF, '0, '0, '0, '0);
    queue_req(REQ_NONE, 32'h1, 64'h5, 64'h5, 32'h1, 32'h1);
    queue_req(REQ_CREATE, 32'h0, 64'd0, 64'd1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(REQ_CREATE, 32'hFFFF_FFFF, 64'd5, 64'd0, 32'hA5A5_5A5A, 32'h0);
    queue_req(REQ_CREATE, 32'h7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              32'h0, 32'h5A5A_A5A5);
    queue_req(REQ_CREATE, 32'h0, 64'd10, 64'd20, 32'h1234, 32'h5678);
    queue_req(REQ_TICK, '0, '0, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0, '0, '0);
    for (int k = 0; k < 14; k++)
      queue_req(REQ_CREATE, 32'h100 + k, 64'd1, 64'd0, k, ~k);
    queue_req(REQ_TICK, '0, '0, '0, '0, '0);
    queue_req(REQ_DESTROY, 32'h7, '0, '0, '0, '0);
    drain_and_wait();

    set_tick(32'hFFFF_FFFF);
    queue_req(REQ_TICK, '0, '0, '0, '0, '0);
    for (int k = 0; k < 16; k++)
      queue_req(REQ_CREATE, 32'h200 + k, 64'd3, 64'd0, k, k);
    queue_req(REQ_CREATE, 32'h999, 64'd3, 64'd0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0, '0, '0);
    drain_and_wait();

    run_phase(0, 0, 32'd1, 85);
    run_phase(66, 0, 32'd100, 85);
    run_phase(0, 66, 32'd37, 85);
    run_phase(22, 22, 32'd781250, 85);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ptt_pkg.sv
design/ptt_front.sv
design/ptt_back.sv
design/periodic_timer_table.sv
design/ptt_checker.sv
verif/periodic_timer_table_tb.sv
